// ===== src/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// cam_pkg: shared types and constants of the clock/alarm mode controller
// Display modes, button codes, register indexes, decode windows and the
// hour/minute wrap helpers.
// ----------------------------------------------------------------------------
package cam_pkg;

	typedef logic [4:0] hour_t;
	typedef logic [5:0] minute_t;
	typedef logic [9:0] sample_t;
	typedef logic [1:0] mode_t;
	typedef logic [2:0] button_t;

	localparam mode_t MODE_TIME = 2'd0;
	localparam mode_t MODE_CELS = 2'd1;
	localparam mode_t MODE_FAHR = 2'd2;
	localparam mode_t MODE_SET  = 2'd3;

	localparam button_t BTN_NONE = 3'd0;
	localparam button_t BTN_A    = 3'd1;
	localparam button_t BTN_B    = 3'd2;
	localparam button_t BTN_C    = 3'd3;
	localparam button_t BTN_D    = 3'd4;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic REG_ALARM_HOUR   = 1'b0;
	localparam logic REG_ALARM_MINUTE = 1'b1;

	localparam int unsigned CFG_DATA_W = 6;

	localparam hour_t   ALARM_HOUR_RST   = 5'd18;
	localparam minute_t ALARM_MINUTE_RST = 6'd30;
	localparam hour_t   CUR_HOUR_RST     = 5'd9;
	localparam minute_t CUR_MINUTE_RST   = 6'd25;
	localparam sample_t PREV_SAMPLE_RST  = 10'd1023;

	localparam hour_t   HOUR_MAX   = 5'd23;
	localparam minute_t MINUTE_MAX = 6'd59;

	localparam sample_t EDGE_LEVEL  = 10'd1010;
	localparam sample_t PRESS_LIMIT = 10'd1000;
	localparam sample_t WIN_A_LO = 10'd500;
	localparam sample_t WIN_A_HI = 10'd520;
	localparam sample_t WIN_B_LO = 10'd670;
	localparam sample_t WIN_B_HI = 10'd690;
	localparam sample_t WIN_C_LO = 10'd760;
	localparam sample_t WIN_C_HI = 10'd780;
	localparam sample_t WIN_D_LO = 10'd800;
	localparam sample_t WIN_D_HI = 10'd830;

	typedef struct packed {
		logic    op;
		sample_t button_sample;
	} item_t;

	typedef struct packed {
		mode_t   display_mode;
		hour_t   shown_hours;
		minute_t shown_minutes;
		logic    alarm_match;
		button_t button_code;
	} result_t;

	function automatic hour_t next_hour(input hour_t h);
		return (h >= HOUR_MAX) ? 5'd0 : h + 5'd1;
	endfunction

	function automatic minute_t next_minute(input minute_t m);
		return (m >= MINUTE_MAX) ? 6'd0 : m + 6'd1;
	endfunction

endpackage

// ===== src/cam_if.sv =====
// ----------------------------------------------------------------------------
// cam_if: valid/ready channels of the clock/alarm mode controller
// Input words carry a tick or a button sample; result words carry the display.
// ----------------------------------------------------------------------------
interface cam_item_if;
	logic               valid;
	logic               ready;
	logic               op;
	cam_pkg::sample_t   button_sample;

	modport source (output valid, output op, output button_sample, input ready);
	modport sink   (input valid, input op, input button_sample, output ready);
endinterface

interface cam_result_if;
	logic               valid;
	logic               ready;
	cam_pkg::mode_t     display_mode;
	cam_pkg::hour_t     shown_hours;
	cam_pkg::minute_t   shown_minutes;
	logic               alarm_match;
	cam_pkg::button_t   button_code;

	modport source (output valid, output display_mode, output shown_hours,
		output shown_minutes, output alarm_match, output button_code, input ready);
	modport sink   (input valid, input display_mode, input shown_hours,
		input shown_minutes, input alarm_match, input button_code, output ready);
endinterface

// ===== src/cam_btn_decode.sv =====
// ----------------------------------------------------------------------------
// cam_btn_decode: button ladder decoder
// Detects a falling crossing of the edge level and maps the sample to a key.
// ----------------------------------------------------------------------------
module cam_btn_decode (
	input  logic             is_sample,
	input  cam_pkg::sample_t sample,
	input  cam_pkg::sample_t prev_sample,
	output cam_pkg::button_t code
);

	logic press;

	assign press = is_sample && (sample < cam_pkg::EDGE_LEVEL)
		&& (prev_sample > cam_pkg::EDGE_LEVEL);

	always_comb begin
		code = cam_pkg::BTN_NONE;
		if (press && sample <= cam_pkg::PRESS_LIMIT) begin
			if (sample > cam_pkg::WIN_A_LO && sample < cam_pkg::WIN_A_HI)
				code = cam_pkg::BTN_A;
			else if (sample > cam_pkg::WIN_B_LO && sample < cam_pkg::WIN_B_HI)
				code = cam_pkg::BTN_B;
			else if (sample > cam_pkg::WIN_C_LO && sample < cam_pkg::WIN_C_HI)
				code = cam_pkg::BTN_C;
			else if (sample > cam_pkg::WIN_D_LO && sample < cam_pkg::WIN_D_HI)
				code = cam_pkg::BTN_D;
		end
	end

endmodule

// ===== src/cam_state.sv =====
// ----------------------------------------------------------------------------
// cam_state: time, set-time and mode state with next-state logic
// Applies one word per step strobe and forms the result from the new state.
// ----------------------------------------------------------------------------
module cam_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  cam_pkg::item_t   item,
	input  cam_pkg::hour_t   alarm_hour,
	input  cam_pkg::minute_t alarm_minute,
	output cam_pkg::result_t res
);

	cam_pkg::hour_t   cur_h_q, cur_h_d, set_h_q, set_h_d;
	cam_pkg::minute_t cur_m_q, cur_m_d, set_m_q, set_m_d;
	cam_pkg::mode_t   mode_q, mode_d;
	cam_pkg::sample_t prev_q;
	cam_pkg::button_t code;

	cam_btn_decode u_decode (
		.is_sample   (item.op == cam_pkg::OP_SAMPLE),
		.sample      (item.button_sample),
		.prev_sample (prev_q),
		.code        (code)
	);

	always_comb begin
		cur_h_d = cur_h_q;
		cur_m_d = cur_m_q;
		set_h_d = set_h_q;
		set_m_d = set_m_q;
		mode_d  = mode_q;
		if (item.op == cam_pkg::OP_TICK) begin
			// carry into the hours on minute wrap
			cur_m_d = cam_pkg::next_minute(cur_m_q);
			if (cur_m_q >= cam_pkg::MINUTE_MAX)
				cur_h_d = cam_pkg::next_hour(cur_h_q);
		end else begin
			unique case (code)
				cam_pkg::BTN_A: begin
					if (mode_q == cam_pkg::MODE_TIME) begin
						mode_d  = cam_pkg::MODE_SET;
						set_h_d = cur_h_q;
						set_m_d = cur_m_q;
					end else if (mode_q == cam_pkg::MODE_SET) begin
						mode_d  = cam_pkg::MODE_TIME;
						cur_h_d = set_h_q;
						cur_m_d = set_m_q;
					end
				end
				cam_pkg::BTN_B: begin
					if (mode_q == cam_pkg::MODE_SET)
						set_h_d = cam_pkg::next_hour(set_h_q);
				end
				cam_pkg::BTN_C: begin
					if (mode_q == cam_pkg::MODE_SET)
						set_m_d = cam_pkg::next_minute(set_m_q);
				end
				cam_pkg::BTN_D: begin
					unique case (mode_q)
						cam_pkg::MODE_TIME: mode_d = cam_pkg::MODE_CELS;
						cam_pkg::MODE_CELS: mode_d = cam_pkg::MODE_FAHR;
						cam_pkg::MODE_FAHR: mode_d = cam_pkg::MODE_TIME;
						default:            mode_d = mode_q;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.display_mode  = mode_d;
		res.shown_hours   = (mode_d == cam_pkg::MODE_SET) ? set_h_d : cur_h_d;
		res.shown_minutes = (mode_d == cam_pkg::MODE_SET) ? set_m_d : cur_m_d;
		res.alarm_match   = (cur_h_d == alarm_hour) && (cur_m_d == alarm_minute);
		res.button_code   = code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_h_q <= cam_pkg::CUR_HOUR_RST;
			cur_m_q <= cam_pkg::CUR_MINUTE_RST;
			set_h_q <= '0;
			set_m_q <= '0;
			mode_q  <= cam_pkg::MODE_TIME;
			prev_q  <= cam_pkg::PREV_SAMPLE_RST;
		end else if (step) begin
			cur_h_q <= cur_h_d;
			cur_m_q <= cur_m_d;
			set_h_q <= set_h_d;
			set_m_q <= set_m_d;
			mode_q  <= mode_d;
			if (item.op == cam_pkg::OP_SAMPLE)
				prev_q <= item.button_sample;
		end
	end

endmodule

// ===== src/clock_alarm_mode_controller.sv =====
// A word taken into the input register moves on into the result register once
// that register is empty or its word is taken. Throughput: one word per cycle
// while result words are taken; the input register refills while the result
// register drains, all work sits in one combinational stage between them.
// Reset (arst_n low, asynchronous): time 09:25, set time 00:00, time display,
// previous sample 1023, alarm 18:30, both stages empty.
// ----------------------------------------------------------------------------
// clock_alarm_mode_controller: digital clock with alarm compare and set mode
// Minute ticks advance the clock; ladder samples drive set and display modes.
// ----------------------------------------------------------------------------
module clock_alarm_mode_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	cam_item_if.sink                         item,
	cam_result_if.source                     result,
	input  logic                             wr_en,
	input  logic                             wr_index,
	input  logic [cam_pkg::CFG_DATA_W-1:0]   wr_data
);

	logic             valid_s1;
	cam_pkg::item_t   item_s1;
	logic             res_valid_q;
	cam_pkg::result_t res_q;
	cam_pkg::result_t res_d;
	cam_pkg::hour_t   alarm_hour_q;
	cam_pkg::minute_t alarm_minute_q;
	logic             advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_hour_q   <= cam_pkg::ALARM_HOUR_RST;
			alarm_minute_q <= cam_pkg::ALARM_MINUTE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				cam_pkg::REG_ALARM_HOUR:   alarm_hour_q   <= wr_data[4:0];
				cam_pkg::REG_ALARM_MINUTE: alarm_minute_q <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.valid && item.ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op            <= item.op;
			item_s1.button_sample <= item.button_sample;
		end
	end

	cam_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.alarm_hour   (alarm_hour_q),
		.alarm_minute (alarm_minute_q),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign result.valid         = res_valid_q;
	assign result.display_mode  = res_q.display_mode;
	assign result.shown_hours   = res_q.shown_hours;
	assign result.shown_minutes = res_q.shown_minutes;
	assign result.alarm_match   = res_q.alarm_match;
	assign result.button_code   = res_q.button_code;

	// an empty input stage must always take a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stage empty but not ready");

	// a tick never reports a button
	a_tick_no_button: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == cam_pkg::OP_TICK
		|=> res_q.button_code == cam_pkg::BTN_NONE)
		else $error("button code on a tick word");

	// shown time stays in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.shown_hours <= cam_pkg::HOUR_MAX
			&& res_q.shown_minutes <= cam_pkg::MINUTE_MAX))
		else $error("shown time out of range");

	// a new result word only appears after a step
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance))
		else $error("result word without a step");

endmodule
